// ===== hw/rtl/ndps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ndps_pkg;

    // Field widths of the streams.
    localparam int OPND_W = 16;
    localparam int PROD_W = 2 * OPND_W;
    localparam int ACC_W  = 48;
    localparam int ACT_W  = 16;

    // Sigmoid table geometry.
    localparam int SIG_DEPTH = 1024;
    localparam int SIG_IDX_W = $clog2(SIG_DEPTH);

    localparam longint Q30_ONE = 64'sd1 << 30;

    typedef logic [ACT_W-1:0] sig_rom_t [SIG_DEPTH];

    // Finished sum of one neuron together with the bias of its last element.
    typedef struct packed {
        logic signed [ACC_W-1:0]  sum;
        logic signed [OPND_W-1:0] bias;
    } ndps_pre_t;

    // Unsigned quotient by shift and subtract; only ever evaluated at elaboration.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned dvs);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int bit_pos = 63; bit_pos >= 0; bit_pos--)
        begin
            rem = {rem[62:0], num[bit_pos]};
            if (rem >= dvs)
            begin
                rem          = rem - dvs;
                quo[bit_pos] = 1'b1;
            end
        end
        return quo;
    endfunction

    // One table sample, evaluated at elaboration only: series for exp(-|2x|/32),
    // five rounded squarings, then a rounded quotient.
    function automatic logic [ACT_W-1:0] sig_sample(input int idx);
        longint          n;
        longint          an;
        longint          y;
        longint          e;
        longint          term;
        longint unsigned p;
        longint unsigned den;
        longint unsigned s;
        n  = 2 * longint'(idx) - longint'(SIG_DEPTH);
        an = (n < 0) ? -n : n;
        // The table depth is a power of two, so halving it again is a shift.
        y  = (an * Q30_ONE + longint'(SIG_DEPTH)) >>> (SIG_IDX_W + 1);
        e    = Q30_ONE;
        term = Q30_ONE;
        for (int k = 1; k <= 12; k++)
        begin
            term = longint'(udiv64(64'((term * y) >>> 30), 64'(k)));
            e = (k[0] == 1'b1) ? e - term : e + term;
        end
        p = longint'(e);
        for (int k = 0; k < 5; k++)
        begin
            p = (p * p + (64'd1 << 29)) >> 30;
        end
        den = 64'(Q30_ONE) + p;
        s   = udiv64(p * 64'd65536 + (den >> 1), den);
        if (n >= 0)
        begin
            s = 64'd65536 - s;
        end
        if (s > 64'd65535)
        begin
            s = 64'd65535;
        end
        return s[ACT_W-1:0];
    endfunction

    function automatic sig_rom_t build_sig_rom();
        sig_rom_t rom;
        for (int i = 0; i < SIG_DEPTH; i++)
        begin
            rom[i] = sig_sample(i);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ndps_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input register, multiplier stage and the wide accumulator. Only last
// elements leave this module, carrying the finished sum and their bias.
module ndps_mac (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [ndps_pkg::OPND_W-1:0] in_data,
    input  wire logic signed [ndps_pkg::OPND_W-1:0] in_weight,
    input  wire logic signed [ndps_pkg::OPND_W-1:0] in_bias,
    input  wire logic                           in_last,
    output logic                                pre_valid,
    input  wire logic                           pre_ready,
    output ndps_pkg::ndps_pre_t                 pre
);
    import ndps_pkg::*;

    logic                     a_valid_reg;
    logic signed [OPND_W-1:0] a_data_reg;
    logic signed [OPND_W-1:0] a_weight_reg;
    logic signed [OPND_W-1:0] a_bias_reg;
    logic                     a_last_reg;

    logic                     b_valid_reg;
    logic signed [PROD_W-1:0] b_prod_reg;
    logic signed [OPND_W-1:0] b_bias_reg;
    logic                     b_last_reg;

    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic                     c_valid_reg;
    ndps_pre_t                c_pre_reg;

    logic a_adv;
    logic b_adv;

    // A non-last element only needs the accumulator, never the result slot.
    assign b_adv    = b_valid_reg && (!b_last_reg || !c_valid_reg || pre_ready);
    assign a_adv    = a_valid_reg && (!b_valid_reg || b_adv);
    assign in_ready = !a_valid_reg || a_adv;

    assign acc_next = acc_reg + ACC_W'(b_prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (!b_valid_reg || b_adv)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (b_adv)
            begin
                acc_reg <= b_last_reg ? '0 : acc_next;
            end
            if (b_adv && b_last_reg)
            begin
                c_valid_reg <= 1'b1;
            end
            else if (pre_ready)
            begin
                c_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_data_reg   <= in_data;
            a_weight_reg <= in_weight;
            a_bias_reg   <= in_bias;
            a_last_reg   <= in_last;
        end
        if (a_adv)
        begin
            b_prod_reg <= a_data_reg * a_weight_reg;
            b_bias_reg <= a_bias_reg;
            b_last_reg <= a_last_reg;
        end
        if (b_adv && b_last_reg)
        begin
            c_pre_reg.sum  <= acc_next;
            c_pre_reg.bias <= b_bias_reg;
        end
    end

    assign pre_valid = c_valid_reg;
    assign pre       = c_pre_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ndps_act.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bias subtraction with rounding and saturation to Q3.12, then the
// nearest-entry sigmoid table and the output register.
module ndps_act (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pre_valid,
    output logic                            pre_ready,
    input  wire ndps_pkg::ndps_pre_t        pre,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [ndps_pkg::ACT_W-1:0]      out_data
);
    import ndps_pkg::*;

    localparam sig_rom_t SIG_ROM   = build_sig_rom();
    localparam int       PRE_W     = ACC_W + 1;
    localparam int       Q_FULL_W  = PRE_W - 12;
    localparam int       IDX_FULL_W = OPND_W + SIG_IDX_W + 2;

    logic signed [PRE_W-1:0]     pre_full;
    logic signed [Q_FULL_W-1:0]  q_full;
    logic signed [OPND_W-1:0]    q_next;

    logic                        q_valid_reg;
    logic signed [OPND_W-1:0]    q_reg;

    logic [OPND_W-1:0]           u;
    logic [IDX_FULL_W-1:0]       idx_full;
    logic [SIG_IDX_W-1:0]        idx;

    logic                        o_valid_reg;
    logic [ACT_W-1:0]            o_data_reg;

    logic q_adv;

    // Round half up: add half an LSB, then an arithmetic shift floors.
    always_comb
    begin
        pre_full = PRE_W'(pre.sum) - (PRE_W'(pre.bias) <<< 12) + PRE_W'(2048);
        q_full   = pre_full[PRE_W-1:12];
        if (q_full > Q_FULL_W'(32767))
        begin
            q_next = 16'sh7fff;
        end
        else if (q_full < -Q_FULL_W'(32768))
        begin
            q_next = 16'sh8000;
        end
        else
        begin
            q_next = q_full[OPND_W-1:0];
        end
    end

    // Offset the code to unsigned and scale to the nearest table sample.
    always_comb
    begin
        u        = {~q_reg[OPND_W-1], q_reg[OPND_W-2:0]};
        idx_full = (IDX_FULL_W'(u) * IDX_FULL_W'(SIG_DEPTH) + IDX_FULL_W'(32768)) >> 16;
        if (idx_full >= IDX_FULL_W'(SIG_DEPTH))
        begin
            idx = SIG_IDX_W'(SIG_DEPTH - 1);
        end
        else
        begin
            idx = idx_full[SIG_IDX_W-1:0];
        end
    end

    assign q_adv     = q_valid_reg && (!o_valid_reg || out_ready);
    assign pre_ready = !q_valid_reg || q_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (pre_ready)
            begin
                q_valid_reg <= pre_valid;
            end
            if (!o_valid_reg || out_ready)
            begin
                o_valid_reg <= q_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pre_valid && pre_ready)
        begin
            q_reg <= q_next;
        end
        if (q_adv)
        begin
            o_data_reg <= SIG_ROM[idx];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/neuron_dot_product_sigmoid.sv =====
// The activation is valid on m_axis once the element marked last has passed the
// input, product, result, pre-activation and output registers; earlier elements
// produce no output. Throughput: one element per cycle while m_axis takes results.
// Reset (rst_n low, asynchronous) empties every stage and clears the accumulator.
`timescale 1ns / 1ps
`default_nettype none

// One neuron: each transaction on s_axis carries a data element, its weight and
// the bias. Products are summed exactly in a 48-bit accumulator that wraps on
// overflow. The transaction with tlast set closes the vector: its product is
// added, the bias (Q3.12) is subtracted, the result is rounded to Q3.12 and
// saturated to [-8, 8), and a 1024-entry sigmoid table gives the unsigned Q0.16
// activation sent on m_axis. The accumulator then starts again from zero.
//
// Pipeline: input register, product register, accumulator with a result slot,
// rounded pre-activation register, output register. Every stage moves on when
// the next one has room, so input is taken while a result waits on m_axis.
module neuron_dot_product_sigmoid (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] data_value, [31:16] weight_value, [47:32] neuron_bias
    input  wire logic [47:0] s_axis_tdata,
    // last_element
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] activation
    output logic [15:0]      m_axis_tdata
);
    import ndps_pkg::*;

    logic      pre_valid;
    logic      pre_ready;
    ndps_pre_t pre;

    ndps_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata[15:0]),
        .in_weight (s_axis_tdata[31:16]),
        .in_bias   (s_axis_tdata[47:32]),
        .in_last   (s_axis_tlast),
        .pre_valid (pre_valid),
        .pre_ready (pre_ready),
        .pre       (pre)
    );

    ndps_act u_act (
        .clk       (clk),
        .rst_n     (rst_n),
        .pre_valid (pre_valid),
        .pre_ready (pre_ready),
        .pre       (pre),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
